/* sv/local_minimum_3x3_defines.svh */
// Assertion helpers for the 3x3 local-minimum detector.
// Both expect i_clk and i_rst_n in the enclosing scope.
`ifndef LOCAL_MINIMUM_3X3_DEFINES_SVH
`define LOCAL_MINIMUM_3X3_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LMIN3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LMIN3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lmin3_pkg.sv */
package lmin3_pkg;

    localparam int CFG_W     = 11;  // config data width
    localparam int CFG_IDX_W = 1;   // config register index width
    localparam int IDX_W     = 20;  // raster index width of a decision

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } t_reg_idx;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Which window rows / columns hold in-grid neighbors.
    // The middle row and the right column always take part.
    typedef struct packed {
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_mid;
    } t_mask;

    // Per-transaction decision control, worked out from the position and the frame dimensions.
    typedef struct packed {
        logic  emit;       // this transaction produces a decision
        logic  col_start;  // decide from the window before the shift
        logic  fend;       // decision for the last pixel of the frame
        t_mask mask;
    } t_ctrl;

endpackage

/* sv/local_minimum_3x3.sv */
// 3x3 local-minimum detector over a raster stream of scores.
// Throughput: one transaction per cycle unless the output stalls; the line store reads and
// writes on separate ports. With the output free, a decision is registered into the output
// register once its trigger (frame_cols+1 places after its pixel) is accepted.
// Reset: synchronous, active low; dimensions go to min(1024, MAX), position and
// count to zero. Line store is not cleared: decisions use only entries of this frame.
`include "local_minimum_3x3_defines.svh"

module local_minimum_3x3
    import lmin3_pkg::*;
#(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int SCORE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [SCORE_WIDTH-1:0] i_score_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [IDX_W-1:0]       o_pixel_index,
    output logic [SCORE_WIDTH-1:0] o_score_out,
    output logic                   o_is_min,
    output logic                   o_frame_end
);

    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int COL_DW   = $clog2(MAX_COLS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 2);
    localparam int LINE_W   = 2 * SCORE_WIDTH;
    localparam int RST_COLS = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int RST_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    // geometry and position
    logic [COL_DW-1:0] r_cols, n_cols;
    logic [ROW_W-1:0]  r_rows, n_rows;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_dcount, n_dcount;

    // decision stage
    logic                   r_s1_valid;
    t_ctrl                  r_s1_ctrl;
    logic [COL_W-1:0]       r_s1_addr;
    logic [IDX_W-1:0]       r_s1_idx;
    logic [SCORE_WIDTH-1:0] r_s1_score;
    logic                   r_fwd;
    logic [LINE_W-1:0]      r_fwd_data;
    logic [SCORE_WIDTH-1:0] r_win [3][3];

    // result register
    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_idx;
    logic [SCORE_WIDTH-1:0] r_out_score;
    logic                   r_out_min;
    logic                   r_out_fend;

    logic                   in_acc;
    logic                   s1_go;
    t_ctrl                  ctrl;
    logic [SCORE_WIDTH-1:0] score_s;
    logic [LINE_W-1:0]      ram_rdata;
    logic [LINE_W-1:0]      line;
    logic [LINE_W-1:0]      wr_line;
    logic [SCORE_WIDTH-1:0] nw [3][3];
    logic [SCORE_WIDTH-1:0] centre;
    logic                   is_min;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;
    assign score_s    = (i_opcode == OP_FLUSH) ? '0 : i_score_in;

    // Decision control from the position of the incoming transaction
    always_comb begin
        logic cs;
        logic inrow;
        cs    = (r_col == '0) && (r_row >= ROW_W'(2)) && (r_row <= r_rows + ROW_W'(1));
        inrow = (r_col != '0) && (r_row >= ROW_W'(1)) && (r_row <= r_rows);
        ctrl.emit      = cs || inrow;
        ctrl.col_start = cs;
        ctrl.fend      = cs && (r_row == r_rows + ROW_W'(1));
        if (cs) begin
            ctrl.mask.row_top  = (r_row >= ROW_W'(3));
            ctrl.mask.row_bot  = (r_row <= r_rows);
            ctrl.mask.col_left = 1'b0;
            ctrl.mask.col_mid  = (r_cols >= COL_DW'(2));
        end else begin
            ctrl.mask.row_top  = (r_row >= ROW_W'(2));
            ctrl.mask.row_bot  = (r_row < r_rows);
            ctrl.mask.col_left = (r_col >= COL_W'(2));
            ctrl.mask.col_mid  = 1'b1;
        end
    end

    // Dimension clamp on a register write
    always_comb begin
        n_cols = r_cols;
        n_rows = r_rows;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FRAME_COLS: begin
                    if (i_cfg_data == '0) begin
                        n_cols = COL_DW'(1);
                    end else if (32'(i_cfg_data) > MAX_COLS) begin
                        n_cols = COL_DW'(MAX_COLS);
                    end else begin
                        n_cols = COL_DW'(i_cfg_data);
                    end
                end
                REG_FRAME_ROWS: begin
                    if (i_cfg_data == '0) begin
                        n_rows = ROW_W'(1);
                    end else if (32'(i_cfg_data) > MAX_ROWS) begin
                        n_rows = ROW_W'(MAX_ROWS);
                    end else begin
                        n_rows = ROW_W'(i_cfg_data);
                    end
                end
                default: begin
                    n_cols = r_cols;
                end
            endcase
        end
    end

    // Position advance; a register write or the frame_end decision restarts the frame
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_dcount = r_dcount;
        if (i_cfg_we) begin
            n_col    = '0;
            n_row    = '0;
            n_dcount = '0;
        end else if (in_acc) begin
            if (COL_DW'(r_col) + COL_DW'(1) >= r_cols) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (ctrl.emit) begin
                n_dcount = r_dcount + IDX_W'(1);
            end
            if (ctrl.fend) begin
                n_col    = '0;
                n_row    = '0;
                n_dcount = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= COL_DW'(RST_COLS);
            r_rows   <= ROW_W'(RST_ROWS);
            r_col    <= '0;
            r_row    <= '0;
            r_dcount <= '0;
        end else begin
            r_cols   <= n_cols;
            r_rows   <= n_rows;
            r_col    <= n_col;
            r_row    <= n_row;
            r_dcount <= n_dcount;
        end
    end

    // Line store: upper half is the row above the middle row at each column
    lmin3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_line),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Read colliding with the write of the transaction ahead takes the new data
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctrl  <= ctrl;
            r_s1_addr  <= r_col;
            r_s1_idx   <= r_dcount;
            r_s1_score <= score_s;
            r_fwd      <= s1_go && (r_s1_addr == r_col);
            r_fwd_data <= wr_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign line    = r_fwd ? r_fwd_data : ram_rdata;
    assign wr_line = {line[SCORE_WIDTH-1:0], r_s1_score};

    // Shifted window and the minimum test
    always_comb begin
        logic [SCORE_WIDTH-1:0] v [3][3];
        logic                   use_row [3];
        logic                   use_col [3];
        for (int k = 0; k < 3; k++) begin
            nw[k][0] = r_win[k][1];
            nw[k][1] = r_win[k][2];
        end
        nw[0][2] = line[LINE_W-1:SCORE_WIDTH];
        nw[1][2] = line[SCORE_WIDTH-1:0];
        nw[2][2] = r_s1_score;

        use_row[0] = r_s1_ctrl.mask.row_top;
        use_row[1] = 1'b1;
        use_row[2] = r_s1_ctrl.mask.row_bot;
        use_col[0] = r_s1_ctrl.mask.col_left;
        use_col[1] = r_s1_ctrl.mask.col_mid;
        use_col[2] = 1'b1;

        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                v[k][j] = r_s1_ctrl.col_start ? r_win[k][j] : nw[k][j];
            end
        end
        centre = r_s1_ctrl.col_start ? r_win[1][2] : nw[1][1];

        is_min = 1'b1;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (use_row[k] && use_col[j] && (v[k][j] < centre)) begin
                    is_min = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_win <= nw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctrl.emit) begin
            r_out_idx   <= r_s1_idx;
            r_out_score <= centre;
            r_out_min   <= is_min;
            r_out_fend  <= r_s1_ctrl.fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_score_out   = r_out_score;
    assign o_is_min      = r_out_min;
    assign o_frame_end   = r_out_fend;

    `LMIN3_ASSERT_NOW(a_col_in_width, 1'b1, COL_DW'(r_col) < r_cols,
        "column position outside the frame width")
    `LMIN3_ASSERT_NOW(a_row_bound, 1'b1, r_row <= r_rows + ROW_W'(1),
        "row position past the flush row")
    `LMIN3_ASSERT_NEXT(a_fend_restart, in_acc && ctrl.fend,
        (r_col == '0) && (r_row == '0) && (r_dcount == '0),
        "frame end did not restart the position")
    `LMIN3_ASSERT_NEXT(a_decision_loaded, s1_go && r_s1_ctrl.emit, o_out_valid,
        "decision not presented after the stage fired")

endmodule

/* sv/lmin3_ram.sv */
module lmin3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
